// ===== hdl/krs_pkg.sv =====
// Shared types, keyword constants and register indexes for the keyword rule scanner.
package krs_pkg;

    localparam int NUM_KW     = 6;
    localparam int HIST_DEPTH = 11;
    localparam int WIN_BITS   = (HIST_DEPTH + 1) * 8;
    localparam int NUM_RULES  = 4;

    localparam int KW_ALTER     = 0;
    localparam int KW_GOTO      = 1;
    localparam int KW_DEPENDING = 2;
    localparam int KW_PERFORM   = 3;
    localparam int KW_THRU      = 4;
    localparam int KW_CICS      = 5;

    localparam logic [6:0] SCORE_FULL = 7'd100;

    // keyword text, right-justified: the last character sits in bits [7:0]
    localparam logic [WIN_BITS-1:0] KW_TEXT [NUM_KW] = '{
        WIN_BITS'("ALTER"),
        WIN_BITS'("GO TO"),
        WIN_BITS'("DEPENDING ON"),
        WIN_BITS'("PERFORM"),
        WIN_BITS'("THRU"),
        WIN_BITS'("EXEC CICS")
    };

    // compare masks, eight ones per keyword character
    localparam logic [WIN_BITS-1:0] KW_MASK [NUM_KW] = '{
        {{(WIN_BITS-40){1'b0}}, {40{1'b1}}},
        {{(WIN_BITS-40){1'b0}}, {40{1'b1}}},
        {WIN_BITS{1'b1}},
        {{(WIN_BITS-56){1'b0}}, {56{1'b1}}},
        {{(WIN_BITS-32){1'b0}}, {32{1'b1}}},
        {{(WIN_BITS-72){1'b0}}, {72{1'b1}}}
    };

    typedef enum logic [2:0] {
        CFG_MAX_RECORDED   = 3'd0,
        CFG_WEIGHT_ALTER   = 3'd1,
        CFG_WEIGHT_GOTO    = 3'd2,
        CFG_WEIGHT_PERFORM = 3'd3,
        CFG_WEIGHT_CICS    = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic [3:0] violation_mask;
        logic [2:0] violation_total;
        logic       critical_seen;
        logic [6:0] quality_score;
    } t_out_word;

    typedef struct packed {
        logic [2:0] max_recorded;
        logic [6:0] weight_alter;
        logic [6:0] weight_goto_depending;
        logic [6:0] weight_perform_thru;
        logic [6:0] weight_cics;
    } t_cfg;

endpackage

// ===== hdl/krs_matcher.sv =====
// Byte history window, keyword compare and sticky keyword presence flags.
module krs_matcher
    import krs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_in_word         i_word,
    output logic [NUM_KW-1:0] o_seen
);

    logic [WIN_BITS-9:0] r_hist, n_hist;
    logic [NUM_KW-1:0]   r_seen;
    logic [WIN_BITS-1:0] window;
    logic [NUM_KW-1:0]   hit;

    assign window = {r_hist, i_word.text_byte};

    always_comb begin
        for (int id = 0; id < NUM_KW; id++) begin
            hit[id] = ((window ^ KW_TEXT[id]) & KW_MASK[id]) == '0;
        end
    end

    assign o_seen = r_seen | hit;

    always_comb begin
        n_hist = window[WIN_BITS-9:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_seen <= '0;
        end else if (i_step) begin
            if (i_word.final_byte) begin
                r_hist <= '0;
                r_seen <= '0;
            end else begin
                r_hist <= n_hist;
                r_seen <= o_seen;
            end
        end
    end

endmodule

// ===== hdl/krs_scorer.sv =====
// Rule evaluation in fixed order, recording limit and score deduction.
module krs_scorer
    import krs_pkg::*;
(
    input  logic [NUM_KW-1:0] i_seen,
    input  t_cfg              i_cfg,
    output t_out_word         o_result
);

    logic [NUM_RULES-1:0] rule;
    logic [6:0]           weight [NUM_RULES];
    logic [NUM_RULES-1:0] mask;
    logic [2:0]           total;
    logic [8:0]           deduct;

    always_comb begin
        rule[0] = i_seen[KW_ALTER];
        rule[1] = i_seen[KW_GOTO] & i_seen[KW_DEPENDING];
        rule[2] = i_seen[KW_PERFORM] & i_seen[KW_THRU];
        rule[3] = i_seen[KW_CICS];
        weight[0] = i_cfg.weight_alter;
        weight[1] = i_cfg.weight_goto_depending;
        weight[2] = i_cfg.weight_perform_thru;
        weight[3] = i_cfg.weight_cics;

        mask   = '0;
        total  = '0;
        deduct = '0;
        for (int i = 0; i < NUM_RULES; i++) begin
            if (rule[i] && (total < i_cfg.max_recorded)) begin
                mask[i] = 1'b1;
                total   = total + 3'd1;
                deduct  = deduct + {2'b00, weight[i]};
            end
        end

        o_result.violation_mask  = mask;
        o_result.violation_total = total;
        o_result.critical_seen   = mask[0];
        // saturate at zero
        if (deduct >= {2'b00, SCORE_FULL}) begin
            o_result.quality_score = '0;
        end else begin
            o_result.quality_score = SCORE_FULL - deduct[6:0];
        end
    end

endmodule

// ===== hdl/keyword_rule_scanner.sv =====
// Top level: input register, matcher, scorer, result register and config registers.
// A last byte's result word is registered in the result register when the byte steps out of the input register.
// Throughput: one byte per cycle while no final byte is held; non-final bytes keep flowing while a result waits.
// A final byte holds in the input register only while the result register is full
// and stalled. Synchronous active-low reset clears history, flags, handshake state
// and restores the default config (limit 4, weights 15/10/5/5).
module keyword_rule_scanner
    import krs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    logic              r_in_vld;
    t_in_word          r_in;
    logic              r_out_vld;
    t_out_word         r_out;
    t_cfg              r_cfg;
    logic              out_free;
    logic              step;
    logic [NUM_KW-1:0] seen;
    t_out_word         result;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && (!r_in.final_byte || out_free);
    assign o_in_stall = r_in_vld && !step;

    krs_matcher u_matcher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in),
        .o_seen  (seen)
    );

    krs_scorer u_scorer (
        .i_seen   (seen),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= step && r_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.final_byte) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_recorded          <= 3'd4;
            r_cfg.weight_alter          <= 7'd15;
            r_cfg.weight_goto_depending <= 7'd10;
            r_cfg.weight_perform_thru   <= 7'd5;
            r_cfg.weight_cics           <= 7'd5;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MAX_RECORDED:   r_cfg.max_recorded          <= i_cfg_data[2:0];
                CFG_WEIGHT_ALTER:   r_cfg.weight_alter          <= i_cfg_data;
                CFG_WEIGHT_GOTO:    r_cfg.weight_goto_depending <= i_cfg_data;
                CFG_WEIGHT_PERFORM: r_cfg.weight_perform_thru   <= i_cfg_data;
                CFG_WEIGHT_CICS:    r_cfg.weight_cics           <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/krs_checker.sv =====
// Port-level assertions for the keyword rule scanner, bound to the top level.
module krs_checker
    import krs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.quality_score <= SCORE_FULL))
        else $error("score above full");

    a_total_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones(o_out_word.violation_mask) ==
                         int'(o_out_word.violation_total)))
        else $error("total does not match mask");

    a_critical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.critical_seen == o_out_word.violation_mask[0]))
        else $error("critical flag does not match alter bit");

endmodule

bind keyword_rule_scanner krs_checker u_krs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
